### hdl/assert_macros.svh
// Assertion helpers used by the checker file gtdh_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising edge, off while reset is held.
`define CHK_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled at the rising edge, off while reset is held.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gtdh_pkg.sv
package gtdh_pkg;

    // Default sizes
    localparam int GTDH_HIST_BINS    = 4096;
    localparam int GTDH_NUM_CHANNELS = 1024;
    localparam int GTDH_COUNT_WIDTH  = 32;

    // Field widths
    localparam int KIND_W      = 2;
    localparam int CHAN_W      = 16;
    localparam int TS_W        = 48;
    localparam int CHARGE_W    = 24;
    localparam int BIN_W       = 12;
    localparam int STATUS_W    = 3;
    localparam int OUT_COUNT_W = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GATE_LOW     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GATE_HIGH    = 2'd3;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FIRST    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COUNTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOCOUNT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DISORDER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd5;

    typedef struct packed {
        logic        [CHAN_W-1:0]   channel_low;
        logic        [CHAN_W-1:0]   channel_high;
        logic signed [CHARGE_W-1:0] energy_gate_low;
        logic signed [CHARGE_W-1:0] energy_gate_high;
    } t_cfg;

endpackage

### hdl/gtdh_cfg_regs.sv
module gtdh_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gtdh_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [gtdh_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [gtdh_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output gtdh_pkg::t_cfg                   o_cfg
);
    import gtdh_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_low      <= '0;
            r_cfg.channel_high     <= CHAN_W'(1023);
            r_cfg.energy_gate_low  <= '0;
            r_cfg.energy_gate_high <= CHARGE_W'(24'h7FFFFF);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CHANNEL_LOW:  r_cfg.channel_low      <= pwdata[CHAN_W-1:0];
                REG_CHANNEL_HIGH: r_cfg.channel_high     <= pwdata[CHAN_W-1:0];
                REG_GATE_LOW:     r_cfg.energy_gate_low  <= pwdata[CHARGE_W-1:0];
                REG_GATE_HIGH:    r_cfg.energy_gate_high <= pwdata[CHARGE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sign-extend the gate limits on readback
    always_comb begin
        unique case (reg_idx)
            REG_CHANNEL_LOW:  prdata = CFG_DATA_W'(r_cfg.channel_low);
            REG_CHANNEL_HIGH: prdata = CFG_DATA_W'(r_cfg.channel_high);
            REG_GATE_LOW:     prdata = {{(CFG_DATA_W-CHARGE_W){r_cfg.energy_gate_low[CHARGE_W-1]}},
                                        r_cfg.energy_gate_low};
            REG_GATE_HIGH:    prdata = {{(CFG_DATA_W-CHARGE_W){r_cfg.energy_gate_high[CHARGE_W-1]}},
                                        r_cfg.energy_gate_high};
            default:          prdata = '0;
        endcase
    end

endmodule

### hdl/gtdh_ram.sv
module gtdh_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old word when the same entry is written in that cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/gated_time_difference_histogram_unit.sv
// Gated time-difference histogram. Detector events (kind 0) whose channel lies in
// [channel_low, channel_high] and whose channel-table entry is set are paired with the
// previous such event; a positive time difference below HIST_BINS, with both charges
// inside the energy gate, increments that histogram bin (saturating). Kind 1 reads a
// bin, kind 2 writes a channel-table entry; every item yields exactly one result.
// Rate: one item per clock cycle sustained while the receiver does not stall the result
// channel; each item passes through stage 1, stage 2 and the output register. The rate
// is set by the histogram read-modify-write: read as the item leaves stage 1, incremented
// and written back as it leaves stage 2, with a forwarding path when consecutive items hit
// the same bin. After reset the input stalls while both memories are swept to zero;
// configuration writes are taken during that sweep.
module gated_time_difference_histogram_unit #(
    parameter int HIST_BINS    = gtdh_pkg::GTDH_HIST_BINS,
    parameter int NUM_CHANNELS = gtdh_pkg::GTDH_NUM_CHANNELS,
    parameter int COUNT_WIDTH  = gtdh_pkg::GTDH_COUNT_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic        [gtdh_pkg::KIND_W-1:0]   i_kind,
    input  logic        [gtdh_pkg::CHAN_W-1:0]   i_channel,
    input  logic        [gtdh_pkg::TS_W-1:0]     i_timestamp,
    input  logic signed [gtdh_pkg::CHARGE_W-1:0] i_charge,
    input  logic        [gtdh_pkg::BIN_W-1:0]    i_bin_index,
    input  logic                                 i_qualifies,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [gtdh_pkg::STATUS_W-1:0]        o_status,
    output logic [gtdh_pkg::TS_W-1:0]            o_time_difference,
    output logic [gtdh_pkg::OUT_COUNT_W-1:0]     o_bin_count,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gtdh_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [gtdh_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [gtdh_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import gtdh_pkg::*;

    localparam int HA        = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam int CA        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CLR_DEPTH = (HIST_BINS > NUM_CHANNELS) ? HIST_BINS : NUM_CHANNELS;
    localparam int CLRW      = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
    localparam int CHAN_XW   = CHAN_W + 1;
    localparam int CLR_XW    = CLRW + 1;

    localparam logic [TS_W-1:0]        BINS_TS   = TS_W'(HIST_BINS);
    localparam logic [CHAN_XW-1:0]     NCH_X     = CHAN_XW'(NUM_CHANNELS);
    localparam logic [CLR_XW-1:0]      CLR_HB    = CLR_XW'(HIST_BINS);
    localparam logic [CLR_XW-1:0]      CLR_NCH   = CLR_XW'(NUM_CHANNELS);
    localparam logic [CLRW-1:0]        CLR_LAST  = CLRW'(CLR_DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    t_cfg cfg;

    gtdh_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ------------------------------------------------------------------
    // Pipeline control: S1 (table data), S2 (histogram data), output reg
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic r_clearing;
    logic [CLRW-1:0] r_clr;
    logic accept, mv1, mv2;

    assign mv2     = r_s2_valid && (!r_out_valid || !i_stall);
    assign mv1     = r_s1_valid && (!r_s2_valid || mv2);
    assign o_stall = r_clearing || (r_s1_valid && !mv1);
    assign accept  = i_valid && !o_stall;

    // Sweep both memories to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            if (r_clr == CLR_LAST) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: channel window and table lookup
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] in_off;
    logic              in_win;
    logic [CA-1:0]     in_idx;

    assign in_off = i_channel - cfg.channel_low;
    assign in_win = (i_channel >= cfg.channel_low) && (i_channel <= cfg.channel_high)
                    && ({1'b0, in_off} < NCH_X);
    assign in_idx = CA'(in_off);

    logic          tab_we, tab_we_pipe;
    logic [CA-1:0] tab_waddr;
    logic [0:0]    tab_wdata;
    logic [0:0]    tab_rdata;

    gtdh_ram #(
        .WIDTH (1),
        .DEPTH (NUM_CHANNELS)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (tab_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    logic [KIND_W-1:0]          r_s1_kind;
    logic                       r_s1_in_win;
    logic [CA-1:0]              r_s1_idx;
    logic [TS_W-1:0]            r_s1_ts;
    logic signed [CHARGE_W-1:0] r_s1_q;
    logic [BIN_W-1:0]           r_s1_bin;
    logic                       r_s1_qual;
    logic                       r_s1_tab_hit;
    logic                       r_s1_tab_fwd;

    // Table write leaves with the item, so the item behind it may need the new bit
    assign tab_we_pipe = mv1 && (r_s1_kind == KIND_WRITE) && r_s1_in_win;
    assign tab_we      = r_clearing ? ({1'b0, r_clr} < CLR_NCH) : tab_we_pipe;
    assign tab_waddr   = r_clearing ? CA'(r_clr) : r_s1_idx;
    assign tab_wdata   = r_clearing ? 1'b0 : r_s1_qual;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (mv1) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind    <= i_kind;
            r_s1_in_win  <= in_win;
            r_s1_idx     <= in_idx;
            r_s1_ts      <= i_timestamp;
            r_s1_q       <= i_charge;
            r_s1_bin     <= i_bin_index;
            r_s1_qual    <= i_qualifies;
            r_s1_tab_hit <= tab_we_pipe && (r_s1_idx == in_idx);
            r_s1_tab_fwd <= r_s1_qual;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: pairing decision against the previous event
    // ------------------------------------------------------------------
    logic [TS_W-1:0]            r_last_time;
    logic signed [CHARGE_W-1:0] r_last_charge;
    logic                       r_have_prev;

    logic signed [CHARGE_W-1:0] gate_lo, gate_hi;
    logic                       tab_bit, qual, ts_lt, d_ok, gate_q, gate_last;
    logic [TS_W-1:0]            diff;

    logic [STATUS_W-1:0] s1_status;
    logic [TS_W-1:0]     s1_diff;
    logic                s1_upd, s1_inc, s1_rd;
    logic [HA-1:0]       s1_addr;

    assign gate_lo   = cfg.energy_gate_low;
    assign gate_hi   = cfg.energy_gate_high;
    assign tab_bit   = r_s1_tab_hit ? r_s1_tab_fwd : tab_rdata[0];
    assign qual      = r_s1_in_win && tab_bit;
    assign ts_lt     = r_s1_ts < r_last_time;
    assign diff      = r_s1_ts - r_last_time;
    assign d_ok      = (diff != '0) && (diff < BINS_TS);
    assign gate_q    = (r_s1_q >= gate_lo) && (r_s1_q <= gate_hi);
    assign gate_last = (r_last_charge >= gate_lo) && (r_last_charge <= gate_hi);

    always_comb begin
        s1_status = ST_IGNORED;
        s1_diff   = '0;
        s1_upd    = 1'b0;
        s1_inc    = 1'b0;
        s1_rd     = 1'b0;
        s1_addr   = HA'(diff);
        case (r_s1_kind)
            KIND_EVENT: begin
                if (qual) begin
                    if (!r_have_prev) begin
                        s1_status = ST_FIRST;
                        s1_upd    = 1'b1;
                    end else if (ts_lt) begin
                        // out of order: drop the event, keep the stored one
                        s1_status = ST_DISORDER;
                    end else begin
                        s1_diff = diff;
                        s1_upd  = 1'b1;
                        if (d_ok && gate_q && gate_last) begin
                            s1_status = ST_COUNTED;
                            s1_inc    = 1'b1;
                            s1_rd     = 1'b1;
                        end else begin
                            s1_status = ST_NOCOUNT;
                        end
                    end
                end
            end
            KIND_READ: begin
                s1_status = ST_DONE;
                s1_addr   = HA'(r_s1_bin);
                s1_rd     = TS_W'(r_s1_bin) < BINS_TS;
            end
            KIND_WRITE: begin
                if (r_s1_in_win) begin
                    s1_status = ST_DONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time   <= '0;
            r_last_charge <= '0;
            r_have_prev   <= 1'b0;
        end else if (mv1 && s1_upd) begin
            r_last_time   <= r_s1_ts;
            r_last_charge <= r_s1_q;
            r_have_prev   <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Histogram memory and stage 2 read-modify-write
    // ------------------------------------------------------------------
    logic [STATUS_W-1:0]    r_s2_status;
    logic [TS_W-1:0]        r_s2_diff;
    logic                   r_s2_inc, r_s2_rd;
    logic [HA-1:0]          r_s2_addr;
    logic                   r_s2_hit;
    logic [COUNT_WIDTH-1:0] r_s2_fwd;

    logic                   hist_we, hist_we_pipe;
    logic [HA-1:0]          hist_waddr;
    logic [COUNT_WIDTH-1:0] hist_wdata, hist_rdata;
    logic [COUNT_WIDTH-1:0] s2_cur, s2_next, s2_count;

    assign hist_we_pipe = mv2 && r_s2_inc;
    assign hist_we      = r_clearing ? ({1'b0, r_clr} < CLR_HB) : hist_we_pipe;
    assign hist_waddr   = r_clearing ? HA'(r_clr) : r_s2_addr;
    assign hist_wdata   = r_clearing ? '0 : s2_next;

    gtdh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (HIST_BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (mv1 && s1_rd),
        .i_raddr (s1_addr),
        .o_rdata (hist_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (mv1) begin
            r_s2_valid <= 1'b1;
        end else if (mv2) begin
            r_s2_valid <= 1'b0;
        end
    end

    // Capture the write that lands in the same cycle as this item's read
    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_s2_status <= s1_status;
            r_s2_diff   <= s1_diff;
            r_s2_inc    <= s1_inc;
            r_s2_rd     <= s1_rd;
            r_s2_addr   <= s1_addr;
            r_s2_hit    <= hist_we_pipe && (r_s2_addr == s1_addr);
            r_s2_fwd    <= s2_next;
        end
    end

    assign s2_cur   = r_s2_hit ? r_s2_fwd : hist_rdata;
    assign s2_next  = (s2_cur == COUNT_MAX) ? s2_cur : s2_cur + COUNT_WIDTH'(1);
    assign s2_count = r_s2_inc ? s2_next : (r_s2_rd ? s2_cur : '0);

    // ------------------------------------------------------------------
    // Output register: hold the result until the transfer completes
    // ------------------------------------------------------------------
    logic [STATUS_W-1:0]    r_out_status;
    logic [TS_W-1:0]        r_out_diff;
    logic [OUT_COUNT_W-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mv2) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_out_status <= r_s2_status;
            r_out_diff   <= r_s2_diff;
            r_out_count  <= OUT_COUNT_W'(s2_count);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_time_difference = r_out_diff;
    assign o_bin_count       = r_out_count;

endmodule

### hdl/gtdh_checker.sv
`include "assert_macros.svh"

module gtdh_checker #(
    parameter int HIST_BINS = gtdh_pkg::GTDH_HIST_BINS
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_stall,
    input logic                               o_valid,
    input logic [gtdh_pkg::STATUS_W-1:0]      o_status,
    input logic [gtdh_pkg::TS_W-1:0]          o_time_difference,
    input logic [gtdh_pkg::OUT_COUNT_W-1:0]   o_bin_count
);
    import gtdh_pkg::*;

    localparam logic [TS_W-1:0] BINS_TS = TS_W'(HIST_BINS);

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")
    `CHK_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_status) && $stable(o_time_difference) && $stable(o_bin_count), "stalled result changed")
    `CHK_IMPLIES(a_counted_range, i_clk, i_rst_n, o_valid && (o_status == ST_COUNTED), (o_time_difference != '0) && (o_time_difference < BINS_TS), "counted difference outside histogram")
    `CHK_IMPLIES(a_diff_zero, i_clk, i_rst_n, o_valid && (o_status != ST_COUNTED) && (o_status != ST_NOCOUNT), o_time_difference == '0, "difference reported without a pair")
    `CHK_IMPLIES(a_count_zero, i_clk, i_rst_n, o_valid && ((o_status == ST_IGNORED) || (o_status == ST_FIRST) || (o_status == ST_NOCOUNT) || (o_status == ST_DISORDER)), o_bin_count == '0, "bin count reported without histogram access")

endmodule

bind gated_time_difference_histogram_unit gtdh_checker #(
    .HIST_BINS (HIST_BINS)
) u_gtdh_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_stall           (i_stall),
    .o_valid           (o_valid),
    .o_status          (o_status),
    .o_time_difference (o_time_difference),
    .o_bin_count       (o_bin_count)
);

### tb/gtdh_result_checker.sv
module gtdh_result_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel, observed
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic        [gtdh_pkg::KIND_W-1:0]     i_kind,
    input  logic        [gtdh_pkg::CHAN_W-1:0]     i_channel,
    input  logic        [gtdh_pkg::TS_W-1:0]       i_timestamp,
    input  logic signed [gtdh_pkg::CHARGE_W-1:0]   i_charge,
    input  logic        [gtdh_pkg::BIN_W-1:0]      i_bin_index,
    input  logic                                   i_qualifies,
    // result channel, observed
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic        [gtdh_pkg::STATUS_W-1:0]   i_status,
    input  logic        [gtdh_pkg::TS_W-1:0]       i_time_difference,
    input  logic        [gtdh_pkg::OUT_COUNT_W-1:0] i_bin_count,
    // configuration port, observed
    input  logic                                   i_psel,
    input  logic                                   i_penable,
    input  logic                                   i_pwrite,
    input  logic                                   i_pready,
    input  logic        [gtdh_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic        [gtdh_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                                     o_pending,
    output int                                     o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;
    import gtdh_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [TS_W-1:0]        time_difference;
        logic [OUT_COUNT_W-1:0] bin_count;
    } t_hist_result;

    // mirrored configuration
    logic        [CHAN_W-1:0]   win_lo;
    logic        [CHAN_W-1:0]   win_hi;
    logic signed [CHARGE_W-1:0] gate_lo;
    logic signed [CHARGE_W-1:0] gate_hi;

    // mirrored block state
    logic        [TS_W-1:0]             prev_ts;
    logic signed [CHARGE_W-1:0]         prev_charge;
    logic                               have_prev;
    logic                               chan_table [GTDH_NUM_CHANNELS];
    logic        [GTDH_COUNT_WIDTH-1:0] hist       [GTDH_HIST_BINS];

    t_hist_result expected_q [$];
    t_hist_result exp_r;
    int           mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic bit window_slot(input logic [CHAN_W-1:0] chan, output int slot);
        slot = int'(chan) - int'(win_lo);
        if (chan < win_lo || chan > win_hi)
            return 1'b0;
        return slot < GTDH_NUM_CHANNELS;
    endfunction

    function automatic bit gated(input logic signed [CHARGE_W-1:0] q);
        return q >= gate_lo && q <= gate_hi;
    endfunction

    function automatic t_hist_result predict_histogram_result(
        input logic        [KIND_W-1:0]   kind,
        input logic        [CHAN_W-1:0]   chan,
        input logic        [TS_W-1:0]     ts,
        input logic signed [CHARGE_W-1:0] q,
        input logic        [BIN_W-1:0]    bin,
        input logic                       qual
    );
        t_hist_result r;
        int           slot;
        bit           hit;
        logic [TS_W-1:0] d;
        r   = '0;
        hit = window_slot(chan, slot);
        case (kind)
            KIND_EVENT: begin
                if (hit && chan_table[slot]) begin
                    if (!have_prev) begin
                        prev_ts     = ts;
                        prev_charge = q;
                        have_prev   = 1'b1;
                        r.status    = ST_FIRST;
                    end else if (ts < prev_ts) begin
                        // out of order: drop the event, keep the state
                        r.status = ST_DISORDER;
                    end else begin
                        d = ts - prev_ts;
                        r.time_difference = d;
                        if (d != 0 && d < GTDH_HIST_BINS && gated(q) && gated(prev_charge)) begin
                            if (hist[d[BIN_W-1:0]] != '1)
                                hist[d[BIN_W-1:0]] = hist[d[BIN_W-1:0]] + 1'b1;
                            r.bin_count = OUT_COUNT_W'(hist[d[BIN_W-1:0]]);
                            r.status    = ST_COUNTED;
                        end else begin
                            r.status = ST_NOCOUNT;
                        end
                        prev_ts     = ts;
                        prev_charge = q;
                    end
                end
            end
            KIND_READ: begin
                r.bin_count = OUT_COUNT_W'(hist[bin]);
                r.status    = ST_DONE;
            end
            KIND_WRITE: begin
                if (hit) begin
                    chan_table[slot] = qual;
                    r.status         = ST_DONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_lo      = '0;
            win_hi      = CHAN_W'(GTDH_NUM_CHANNELS - 1);
            gate_lo     = '0;
            gate_hi     = {1'b0, {(CHARGE_W-1){1'b1}}};
            prev_ts     = '0;
            prev_charge = '0;
            have_prev   = 1'b0;
            for (int k = 0; k < GTDH_NUM_CHANNELS; k++)
                chan_table[k] = 1'b0;
            for (int k = 0; k < GTDH_HIST_BINS; k++)
                hist[k] = '0;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_ADDR_W-1:2])
                    REG_CHANNEL_LOW:  win_lo  = i_pwdata[CHAN_W-1:0];
                    REG_CHANNEL_HIGH: win_hi  = i_pwdata[CHAN_W-1:0];
                    REG_GATE_LOW:     gate_lo = i_pwdata[CHARGE_W-1:0];
                    REG_GATE_HIGH:    gate_hi = i_pwdata[CHARGE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(predict_histogram_result(i_kind, i_channel, i_timestamp,
                                                              i_charge, i_bin_index, i_qualifies));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected: status %0d diff %0d count %0d",
                             $time, i_status, i_time_difference, i_bin_count);
                    mismatch_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_status !== exp_r.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, exp_r.status, i_status);
                        mismatch_count++;
                    end
                    if (i_time_difference !== exp_r.time_difference) begin
                        $display("%0t: time_difference expected %0d got %0d",
                                 $time, exp_r.time_difference, i_time_difference);
                        mismatch_count++;
                    end
                    if (i_bin_count !== exp_r.bin_count) begin
                        $display("%0t: bin_count expected %0d got %0d",
                                 $time, exp_r.bin_count, i_bin_count);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

### tb/gated_time_difference_histogram_unit_tb.sv
module gated_time_difference_histogram_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gtdh_pkg::*;

    // Kind code the block must drop without touching its state.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // Limit on the whole run; keep a wide margin over the slowest run.
    localparam int CYCLE_LIMIT = 500000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic        [KIND_W-1:0]     i_kind;
    logic        [CHAN_W-1:0]     i_channel;
    logic        [TS_W-1:0]       i_timestamp;
    logic signed [CHARGE_W-1:0]   i_charge;
    logic        [BIN_W-1:0]      i_bin_index;
    logic                         i_qualifies;
    logic                         o_valid;
    logic                         i_stall;
    logic        [STATUS_W-1:0]   o_status;
    logic        [TS_W-1:0]       o_time_difference;
    logic        [OUT_COUNT_W-1:0] o_bin_count;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic        [CFG_ADDR_W-1:0] paddr;
    logic        [CFG_DATA_W-1:0] pwdata;
    logic        [CFG_DATA_W-1:0] prdata;
    logic                         pready;

    int pending;
    int mismatches;
    int cycle_count = 0;

    // Sender and receiver pacing. A burst flag turns idling off for a stretch.
    bit tx_burst   = 1'b0;
    bit rx_burst   = 1'b0;
    int stall_left = 0;

    // Stimulus-side copy of the configuration, used only to shape items.
    int              cfg_gl;
    int              cfg_gh;
    logic [TS_W-1:0] cur_ts;

    gated_time_difference_histogram_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (i_kind),
        .i_channel         (i_channel),
        .i_timestamp       (i_timestamp),
        .i_charge          (i_charge),
        .i_bin_index       (i_bin_index),
        .i_qualifies       (i_qualifies),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_time_difference (o_time_difference),
        .o_bin_count       (o_bin_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    gtdh_result_checker result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_kind            (i_kind),
        .i_channel         (i_channel),
        .i_timestamp       (i_timestamp),
        .i_charge          (i_charge),
        .i_bin_index       (i_bin_index),
        .i_qualifies       (i_qualifies),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_status          (o_status),
        .i_time_difference (o_time_difference),
        .i_bin_count       (o_bin_count),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_pending         (pending),
        .o_mismatches      (mismatches)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort on a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gated_time_difference_histogram_unit_tb failed");
            $finish;
        end
    end

    // Receiver: after each result transfer draw a fresh stall length, then
    // hold stall until it runs out. Flip into and out of burst mode now and then.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            stall_left = rx_burst ? 0 : $urandom_range(0, 18);
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Present one item and hold it until the block takes it. Entered and left
    // at a falling edge; valid stays high into the next call when it has no gap.
    task automatic xfer(input logic        [KIND_W-1:0]   kind,
                        input logic        [CHAN_W-1:0]   chan,
                        input logic        [TS_W-1:0]     ts,
                        input logic signed [CHARGE_W-1:0] q,
                        input logic        [BIN_W-1:0]    bin,
                        input logic                       qual);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_channel   <= chan;
        i_timestamp <= ts;
        i_charge    <= q;
        i_bin_index <= bin;
        i_qualifies <= qual;
        do
            @(posedge i_clk);
        while (o_stall);
        @(negedge i_clk);
    endtask

    // Hold until every predicted result has come back. Ends at a falling edge.
    task automatic wait_drained();
        while (pending != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
    endtask

    // Reprogram all four registers with the block drained. The short pause
    // lets the histogram write-back of the last item settle.
    task automatic program_window(input int lo, input int hi, input int glo, input int ghi);
        wait_drained();
        repeat (4) @(negedge i_clk);
        apb_write(REG_CHANNEL_LOW,  CFG_DATA_W'(lo));
        apb_write(REG_CHANNEL_HIGH, CFG_DATA_W'(hi));
        apb_write(REG_GATE_LOW,     CFG_DATA_W'(glo));
        apb_write(REG_GATE_HIGH,    CFG_DATA_W'(ghi));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_gl = glo;
        cfg_gh = ghi;
    endtask

    // Charge mostly inside the current gate, sometimes anywhere.
    function automatic logic signed [CHARGE_W-1:0] draw_charge();
        if ($urandom_range(0, 99) < 85)
            return CHARGE_W'(cfg_gl + int'($urandom_range(0, cfg_gh - cfg_gl)));
        return CHARGE_W'($urandom);
    endfunction

    // Random traffic: mostly ordered event trains on a small set of channels
    // (base..base+15) with short spacings so bins fill up, mixed with reads,
    // table rewrites, out-of-order events, stray channels and unused kinds.
    task automatic run_event_mix(input int n_items, input int chan_base);
        int                r;
        int                step;
        logic [TS_W-1:0]   ts;
        logic [CHAN_W-1:0] chan;
        // jump ahead so the previous phase's last time never blocks this one
        cur_ts = cur_ts + (TS_W'($urandom) << $urandom_range(0, 8));
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) begin
                // stop sending and let the pipeline empty completely
                i_valid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(0, 39) == 0)
                tx_burst = !tx_burst;
            r    = $urandom_range(0, 99);
            chan = CHAN_W'(chan_base + $urandom_range(0, 15));
            if (r < 62) begin
                step = $urandom_range(0, 99);
                if (step < 70)
                    step = $urandom_range(1, 24);
                else if (step < 85)
                    step = $urandom_range(25, 4095);
                else if (step < 93)
                    step = $urandom_range(4096, 200000);
                else
                    step = 0;
                cur_ts = cur_ts + TS_W'(step);
                xfer(KIND_EVENT, chan, cur_ts, draw_charge(), BIN_W'($urandom), 1'($urandom));
            end else if (r < 67) begin
                ts = cur_ts - TS_W'($urandom_range(1, 1000));
                xfer(KIND_EVENT, chan, ts, draw_charge(), BIN_W'($urandom), 1'($urandom));
            end else if (r < 80) begin
                xfer(KIND_READ, CHAN_W'($urandom), TS_W'({$urandom, $urandom}),
                     CHARGE_W'($urandom),
                     ($urandom_range(0, 9) < 7) ? BIN_W'($urandom_range(0, 31))
                                                : BIN_W'($urandom), 1'($urandom));
            end else if (r < 86) begin
                if ($urandom_range(0, 4) != 0)
                    xfer(KIND_WRITE, CHAN_W'(chan_base + $urandom_range(0, 19)),
                         TS_W'({$urandom, $urandom}),
                         CHARGE_W'($urandom), BIN_W'($urandom), $urandom_range(0, 4) != 0);
                else
                    xfer(KIND_WRITE, CHAN_W'($urandom), TS_W'({$urandom, $urandom}),
                         CHARGE_W'($urandom), BIN_W'($urandom), 1'($urandom));
            end else if (r < 95) begin
                // stray channel, still moving forward in time
                cur_ts = cur_ts + TS_W'($urandom_range(0, 5000));
                xfer(KIND_EVENT, CHAN_W'($urandom), cur_ts, CHARGE_W'($urandom),
                     BIN_W'($urandom), 1'($urandom));
            end else begin
                xfer(KIND_UNUSED, CHAN_W'($urandom), TS_W'({$urandom, $urandom}),
                     CHARGE_W'($urandom), BIN_W'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        // drive every input to a known value from time zero
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_kind      = KIND_EVENT;
        i_channel   = '0;
        i_timestamp = '0;
        i_charge    = '0;
        i_bin_index = '0;
        i_qualifies = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cur_ts      = '0;
        cfg_gl      = 0;
        cfg_gh      = 8388607;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Narrow gate, default window. Registers are taken during the clearing sweep.
        program_window(0, 1023, -1000, 5000);

        // Directed: table edges, the first event, every status and the gate edges.
        xfer(KIND_READ,   16'd0,     48'd0, 24'sd0, 12'd0, 1'b0);   // empty bin
        xfer(KIND_WRITE,  16'd0,     48'd0, 24'sd0, 12'd0, 1'b1);
        xfer(KIND_WRITE,  16'd1,     48'd0, 24'sd0, 12'd0, 1'b1);
        xfer(KIND_WRITE,  16'd1023,  48'd0, 24'sd0, 12'd0, 1'b1);   // last table slot
        xfer(KIND_WRITE,  16'd2000,  48'd0, 24'sd0, 12'd0, 1'b1);   // outside window
        xfer(KIND_UNUSED, 16'hffff,  48'hffff_ffff_ffff, -24'sd1, 12'hfff, 1'b1);
        // latest possible time on a channel that does not qualify
        xfer(KIND_EVENT,  16'd2,     48'hffff_ffff_ffff, -24'sd8388608, 12'd0, 1'b0);
        xfer(KIND_EVENT,  16'd0,     48'd1000, 24'sd100,  12'd0, 1'b0);  // first one stored
        xfer(KIND_EVENT,  16'd1,     48'd0,    24'sd100,  12'd0, 1'b0);  // out of order
        xfer(KIND_EVENT,  16'd1,     48'd1000, 24'sd200,  12'd0, 1'b0);  // zero spacing
        xfer(KIND_EVENT,  16'd1023,  48'd1001, 24'sd300,  12'd0, 1'b0);  // bin 1
        xfer(KIND_EVENT,  16'd0,     48'd5096, 24'sd5000, 12'd0, 1'b0);  // top bin, gate top
        xfer(KIND_EVENT,  16'd0,     48'd9192, -24'sd1000, 12'd0, 1'b0); // one past top bin
        xfer(KIND_EVENT,  16'd1,     48'd9193, 24'sd5001, 12'd0, 1'b0);  // above gate
        xfer(KIND_EVENT,  16'd1,     48'd9194, 24'sd0,    12'd0, 1'b0);  // previous out of gate
        xfer(KIND_EVENT,  16'd1,     48'd9195, -24'sd1001, 12'd0, 1'b0); // below gate
        xfer(KIND_EVENT,  16'd0,     48'd9196, 24'sd8388607, 12'd0, 1'b0);
        xfer(KIND_EVENT,  16'd0,     48'd9197, 24'sd0,    12'd0, 1'b0);
        xfer(KIND_EVENT,  16'd0,     48'd9198, 24'sd0,    12'd0, 1'b0);  // bin 1 again
        xfer(KIND_WRITE,  16'd1,     48'd0,    24'sd0,    12'd0, 1'b0);  // clear a slot
        xfer(KIND_EVENT,  16'd1,     48'd9300, 24'sd0,    12'd0, 1'b0);  // now ignored
        xfer(KIND_EVENT,  16'hffff,  48'd9301, 24'sd0,    12'd0, 1'b0);  // beyond window
        xfer(KIND_READ,   16'd0,     48'd0,    24'sd0,    12'd1, 1'b0);
        xfer(KIND_READ,   16'd0,     48'd0,    24'sd0,    12'hfff, 1'b0);
        cur_ts = 48'd9301;

        // fill the rest of the event channels, then random traffic
        for (int c = 2; c < 16; c++)
            xfer(KIND_WRITE, CHAN_W'(c), 48'd0, 24'sd0, 12'd0, 1'b1);
        run_event_mix(350, 0);

        // Window at the top of the channel range, widest possible gate.
        i_valid <= 1'b0;
        program_window(64512, 65535, -8388608, 8388607);
        xfer(KIND_WRITE, 16'hffff, 48'd0, 24'sd0, 12'd0, 1'b1);
        cur_ts = cur_ts + 48'd3;
        xfer(KIND_EVENT, 16'hffff, cur_ts, 24'sd8388607, 12'd0, 1'b0);
        run_event_mix(300, 64512);

        // Full channel range, single-value gate: slots past the table are dropped.
        i_valid <= 1'b0;
        program_window(0, 65535, 0, 0);
        xfer(KIND_WRITE, 16'd1024,  48'd0, 24'sd0, 12'd0, 1'b1);
        xfer(KIND_EVENT, 16'd40000, cur_ts + 48'd5, 24'sd0, 12'd0, 1'b0);
        run_event_mix(250, 0);

        // Empty window: nothing qualifies.
        i_valid <= 1'b0;
        program_window(100, 99, -100, 100);
        run_event_mix(30, 100);

        // Mid-range window.
        i_valid <= 1'b0;
        program_window(300, 700, -50, 50);
        run_event_mix(250, 300);

        i_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("gated_time_difference_histogram_unit_tb passed");
        end else begin
            $display("gated_time_difference_histogram_unit_tb failed");
        end
        $finish;
    end

endmodule
